// ----- rtl/core/lidar_curvature_occlusion_marker_assert.svh -----
`ifndef LIDAR_CURVATURE_OCCLUSION_MARKER_ASSERT_SVH
`define LIDAR_CURVATURE_OCCLUSION_MARKER_ASSERT_SVH

// plain property check on clock, off during reset
`define LCOM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// a stalled beat keeps its payload
`define LCOM_ASSERT_HOLD(label, vld, rdy, sig, msg) \
   `LCOM_ASSERT(label, vld && !rdy |=> $stable(sig), msg)

`endif

// ----- rtl/core/lcom_pkg.sv -----
`default_nettype none

package lcom_pkg;

   localparam int MAX_POINTS = 65536;
   localparam int COLUMNS    = 2048;
   localparam int RANGE_BITS = 18;

   localparam int RANGE_W  = 18;
   localparam int COLUMN_W = 11;
   localparam int INDEX_W  = $clog2(MAX_POINTS);
   localparam int CURV_W   = 43;
   localparam int GAP_W    = 16;
   localparam int LIMIT_W  = 11;
   localparam int RATIO_W  = 10;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int NEIGH      = 5;
   localparam int WIN_DEPTH  = 12;
   localparam int WIN_IDX_W  = $clog2(WIN_DEPTH);
   localparam int FILL_W     = $clog2(WIN_DEPTH + 1);
   localparam int CURV_POS   = NEIGH;
   localparam int TEST_POS   = NEIGH + 1;
   localparam int CURV_FILL  = 2 * NEIGH + 1;
   localparam int SUM_W      = RANGE_W + 4;
   localparam int SQ_W       = 2 * SUM_W;
   localparam int PROD_W     = RANGE_W + RATIO_W;

   localparam logic [RANGE_W-1:0]  RANGE_MASK =
      (RANGE_BITS >= RANGE_W) ? {RANGE_W{1'b1}} : RANGE_W'((64'd1 << RANGE_BITS) - 64'd1);
   localparam logic [COLUMN_W-1:0] COLUMN_MAX = COLUMN_W'(COLUMNS - 1);
   localparam logic [CURV_W-1:0]   CURV_MAX   = {CURV_W{1'b1}};
   localparam logic [RATIO_W-1:0]  PERMILLE   = RATIO_W'(1000);
   localparam logic [FILL_W-1:0]   FILL_FULL  = FILL_W'(WIN_DEPTH);
   localparam logic [FILL_W-1:0]   FILL_CURV  = FILL_W'(CURV_FILL);
   localparam logic [WIN_IDX_W-1:0] OLDEST_POS = WIN_IDX_W'(WIN_DEPTH - 1);

   localparam logic [GAP_W-1:0]   GAP_RESET   = GAP_W'(300);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);
   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(20);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OCCLUSION_GAP  = 2'd0,
      CSR_COLUMN_GAP     = 2'd1,
      CSR_PARALLEL_RATIO = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_ONE,
      EMIT_FLUSH
   } emit_state_type;

   typedef struct packed {
      logic [GAP_W-1:0]   occlusion_gap_mm;
      logic [LIMIT_W-1:0] column_gap_limit;
      logic [RATIO_W-1:0] parallel_ratio_permille;
   } cfg_type;

   typedef struct packed {
      logic              accept;
      logic              last;
      logic [FILL_W-1:0] fill_next;
   } accept_type;

   typedef struct packed {
      logic [WIN_DEPTH-1:0][RANGE_W-1:0]  ranges;
      logic [WIN_DEPTH-1:0][COLUMN_W-1:0] columns;
      logic [WIN_DEPTH-1:0]               excl;
      logic [WIN_DEPTH-1:0][SUM_W-1:0]    curv_abs;
      logic [WIN_DEPTH-1:0]               curv_ok;
      logic [INDEX_W-1:0]                 last_index;
   } window_type;

endpackage

`default_nettype wire

// ----- rtl/core/lcom_if.sv -----
`default_nettype none

interface lcom_req_if import lcom_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RANGE_W-1:0]  range_mm;
   logic [COLUMN_W-1:0] column;
   logic                last_point;

   modport source (output valid, range_mm, column, last_point, input ready);
   modport sink (input valid, range_mm, column, last_point, output ready);
endinterface

interface lcom_rsp_if import lcom_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [INDEX_W-1:0]  point_index;
   logic [RANGE_W-1:0]  range_out;
   logic [COLUMN_W-1:0] column_out;
   logic [CURV_W-1:0]   curvature;
   logic                curvature_valid;
   logic                excluded;
   logic                scan_end;

   modport source (output valid, point_index, range_out, column_out, curvature,
                   curvature_valid, excluded, scan_end, input ready);
   modport sink (input valid, point_index, range_out, column_out, curvature,
                 curvature_valid, excluded, scan_end, output ready);
endinterface

interface lcom_csr_if import lcom_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lidar_curvature_occlusion_marker.sv -----
// channel   dir  beat
// req_in    in   range_mm, column, last_point
// rsp_out   out  point_index, range_out, column_out, curvature, curvature_valid,
//                excluded, scan_end
// csr_in    in   index, data (0 occlusion gap, 1 column gap limit, 2 parallel ratio)
//
// one point per cycle; a point's result leaves once eleven newer points have come in
// a last_point beat flushes up to 12 results, one per cycle while rsp_out is ready
// req_in is held off during the flush and while a result waits in the output register
// with a new result pending; csr_in is always ready, one register per beat
// synchronous reset clears the scan position, fill count, output valid and emit state, and loads the csr defaults
`default_nettype none

module lidar_curvature_occlusion_marker import lcom_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lcom_req_if.sink    req_in,
   lcom_rsp_if.source  rsp_out,
   lcom_csr_if.sink    csr_in
);

   cfg_type           cfg;
   window_type        view;
   accept_type        acc;
   logic [FILL_W-1:0] fill_next;
   logic              req_ready;
   logic              restart;

   assign req_in.ready  = req_ready;
   assign acc.accept    = req_in.valid && req_ready;
   assign acc.last      = req_in.last_point;
   assign acc.fill_next = fill_next;

   lcom_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_in),
      .cfg   (cfg)
   );

   lcom_window u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (acc.accept),
      .restart   (restart),
      .range_mm  (req_in.range_mm),
      .column    (req_in.column),
      .cfg       (cfg),
      .fill_next (fill_next),
      .view      (view)
   );

   lcom_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .acc       (acc),
      .view      (view),
      .req_ready (req_ready),
      .restart   (restart),
      .rsp       (rsp_out)
   );

endmodule

`default_nettype wire

// ----- rtl/core/lcom_csr.sv -----
`default_nettype none

module lcom_csr import lcom_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lcom_csr_if.sink    csr,
   output cfg_type     cfg
);

   cfg_type cfg_ff;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.occlusion_gap_mm        <= GAP_RESET;
         cfg_ff.column_gap_limit        <= LIMIT_RESET;
         cfg_ff.parallel_ratio_permille <= RATIO_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_OCCLUSION_GAP: begin
               cfg_ff.occlusion_gap_mm <= csr.data[GAP_W-1:0];
            end
            CSR_COLUMN_GAP: begin
               cfg_ff.column_gap_limit <= csr.data[LIMIT_W-1:0];
            end
            CSR_PARALLEL_RATIO: begin
               cfg_ff.parallel_ratio_permille <= csr.data[RATIO_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/lcom_window.sv -----
`default_nettype none

module lcom_window import lcom_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                restart,
   input  logic [RANGE_W-1:0]  range_mm,
   input  logic [COLUMN_W-1:0] column,
   input  cfg_type             cfg,
   output logic [FILL_W-1:0]   fill_next,
   output window_type          view
);

   logic [RANGE_W-1:0]  range_ff    [WIN_DEPTH];
   logic [COLUMN_W-1:0] column_ff   [WIN_DEPTH];
   logic                excl_ff     [WIN_DEPTH];
   logic [SUM_W-1:0]    curv_ff     [WIN_DEPTH];
   logic                curv_ok_ff  [WIN_DEPTH];
   logic [FILL_W-1:0]   fill_ff;
   logic [INDEX_W-1:0]  count_ff;
   logic [INDEX_W-1:0]  last_index_ff;

   logic [RANGE_W-1:0]  range_in    [WIN_DEPTH];
   logic [COLUMN_W-1:0] column_in   [WIN_DEPTH];
   logic                excl_in     [WIN_DEPTH];
   logic [SUM_W-1:0]    curv_in     [WIN_DEPTH];
   logic                curv_ok_in  [WIN_DEPTH];

   logic                tests_on;
   logic [RANGE_W-1:0]  r_near;
   logic [RANGE_W-1:0]  r_mid;
   logic [RANGE_W-1:0]  r_far;
   logic [COLUMN_W-1:0] col_diff;
   logic                adjacent;
   logic                mid_farther;
   logic [RANGE_W-1:0]  diff_near;
   logic [RANGE_W-1:0]  diff_far;
   logic                occl_old;
   logic                occl_new;
   logic [PROD_W-1:0]   par_limit;
   logic [PROD_W-1:0]   jump_near;
   logic [PROD_W-1:0]   jump_far;
   logic                parallel;
   logic [SUM_W-1:0]    pair_sum    [NEIGH];
   logic [SUM_W-1:0]    ring_sum;
   logic [SUM_W-1:0]    ten_center;
   logic [SUM_W-1:0]    curv_abs;

   assign fill_next = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + FILL_W'(1);
   assign tests_on  = (fill_next == FILL_FULL);

   always_comb begin
      range_in[0]   = range_mm & RANGE_MASK;
      column_in[0]  = (column > COLUMN_MAX) ? COLUMN_MAX : column;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         range_in[k]  = range_ff[k-1];
         column_in[k] = column_ff[k-1];
      end

      // neighbor tests centered at the test position of the shifted window
      r_near      = range_in[TEST_POS-1];
      r_mid       = range_in[TEST_POS];
      r_far       = range_in[TEST_POS+1];
      col_diff    = (column_in[TEST_POS-1] > column_in[TEST_POS])
                  ? column_in[TEST_POS-1] - column_in[TEST_POS]
                  : column_in[TEST_POS] - column_in[TEST_POS-1];
      adjacent    = col_diff < cfg.column_gap_limit;
      mid_farther = r_mid > r_near;
      diff_near   = mid_farther ? r_mid - r_near : r_near - r_mid;
      diff_far    = (r_far > r_mid) ? r_far - r_mid : r_mid - r_far;
      occl_old    = tests_on && adjacent && mid_farther
                  && (diff_near > RANGE_W'(cfg.occlusion_gap_mm));
      occl_new    = tests_on && adjacent && !mid_farther
                  && (diff_near > RANGE_W'(cfg.occlusion_gap_mm));
      par_limit   = PROD_W'(cfg.parallel_ratio_permille) * PROD_W'(r_mid);
      jump_near   = PROD_W'(diff_near) * PROD_W'(PERMILLE);
      jump_far    = PROD_W'(diff_far) * PROD_W'(PERMILLE);
      parallel    = tests_on && (jump_far > par_limit) && (jump_near > par_limit);

      excl_in[0] = occl_new;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         excl_in[k] = excl_ff[k-1] | ((k >= TEST_POS) ? occl_old : occl_new)
                    | ((k == TEST_POS) ? parallel : 1'b0);
      end

      // ten neighbors around the curvature position, as a short tree
      for (int j = 0; j < NEIGH; j++) begin
         pair_sum[j] = SUM_W'(range_in[j]) + SUM_W'(range_in[j+CURV_POS+1]);
      end
      ring_sum   = (pair_sum[0] + pair_sum[1]) + (pair_sum[2] + pair_sum[3]) + pair_sum[4];
      ten_center = SUM_W'({range_in[CURV_POS], 3'b000}) + SUM_W'({range_in[CURV_POS], 1'b0});
      curv_abs   = (ring_sum >= ten_center) ? ring_sum - ten_center : ten_center - ring_sum;

      curv_in[0]    = '0;
      curv_ok_in[0] = 1'b0;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         curv_in[k]    = curv_ff[k-1];
         curv_ok_in[k] = curv_ok_ff[k-1];
      end
      curv_in[CURV_POS]    = curv_abs;
      curv_ok_in[CURV_POS] = (fill_next >= FILL_CURV);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else if (restart) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         fill_ff  <= fill_next;
         count_ff <= count_ff + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < WIN_DEPTH; k++) begin
            range_ff[k]   <= range_in[k];
            column_ff[k]  <= column_in[k];
            excl_ff[k]    <= excl_in[k];
            curv_ff[k]    <= curv_in[k];
            curv_ok_ff[k] <= curv_ok_in[k];
         end
         last_index_ff <= count_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
         view.ranges[k]   = range_ff[k];
         view.columns[k]  = column_ff[k];
         view.excl[k]     = excl_ff[k];
         view.curv_abs[k] = curv_ff[k];
         view.curv_ok[k]  = curv_ok_ff[k];
      end
      view.last_index = last_index_ff;
   end

endmodule

`default_nettype wire

// ----- rtl/core/lcom_emit.sv -----
`default_nettype none

module lcom_emit import lcom_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  accept_type  acc,
   input  window_type  view,
   output logic        req_ready,
   output logic        restart,
   lcom_rsp_if.source  rsp
);

   emit_state_type       state_ff;
   emit_state_type       state_in;
   logic [WIN_IDX_W-1:0] pos_ff;
   logic [WIN_IDX_W-1:0] pos_in;
   logic                 rsp_valid_ff;

   logic [INDEX_W-1:0]   index_ff;
   logic [RANGE_W-1:0]   range_ff;
   logic [COLUMN_W-1:0]  column_ff;
   logic [CURV_W-1:0]    curv_ff;
   logic                 curv_ok_ff;
   logic                 excl_ff;
   logic                 scan_end_ff;

   logic                 load;
   logic                 group_end;
   logic [SUM_W-1:0]     curv_sel;
   logic [SQ_W-1:0]      square;
   logic [CURV_W-1:0]    curv_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMIT_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_comb begin
      load      = (state_ff != EMIT_IDLE) && (!rsp_valid_ff || rsp.ready);
      group_end = (state_ff == EMIT_ONE) || (pos_ff == '0);
      req_ready = (state_ff == EMIT_IDLE) || ((state_ff == EMIT_ONE) && load);
      restart   = load && (state_ff == EMIT_FLUSH) && (pos_ff == '0);
      state_in  = state_ff;
      pos_in    = pos_ff;
      unique case (state_ff)
         EMIT_IDLE: begin
         end
         EMIT_ONE, EMIT_FLUSH: begin
            if (load) begin
               if (group_end) begin
                  state_in = EMIT_IDLE;
               end else begin
                  pos_in = pos_ff - WIN_IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = EMIT_IDLE;
         end
      endcase
      if (acc.accept) begin
         if (acc.last) begin
            state_in = EMIT_FLUSH;
            pos_in   = WIN_IDX_W'(acc.fill_next - FILL_W'(1));
         end else if (acc.fill_next == FILL_FULL) begin
            state_in = EMIT_ONE;
            pos_in   = OLDEST_POS;
         end
      end
   end

   always_comb begin
      curv_sel = view.curv_abs[pos_ff];
      square   = SQ_W'(curv_sel) * SQ_W'(curv_sel);
      curv_sat = (square > SQ_W'(CURV_MAX)) ? CURV_MAX : square[CURV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff    <= view.last_index - INDEX_W'(pos_ff);
         range_ff    <= view.ranges[pos_ff];
         column_ff   <= view.columns[pos_ff];
         curv_ok_ff  <= view.curv_ok[pos_ff];
         curv_ff     <= view.curv_ok[pos_ff] ? curv_sat : '0;
         excl_ff     <= view.excl[pos_ff];
         scan_end_ff <= (state_ff == EMIT_FLUSH) && (pos_ff == '0);
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.point_index     = index_ff;
   assign rsp.range_out       = range_ff;
   assign rsp.column_out      = column_ff;
   assign rsp.curvature       = curv_ff;
   assign rsp.curvature_valid = curv_ok_ff;
   assign rsp.excluded        = excl_ff;
   assign rsp.scan_end        = scan_end_ff;

endmodule

`default_nettype wire

// ----- rtl/core/lcom_checker.sv -----
`default_nettype none

`include "lidar_curvature_occlusion_marker_assert.svh"

module lcom_checker import lcom_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_last,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [INDEX_W-1:0]  rsp_point_index,
   input logic [CURV_W-1:0]   rsp_curvature,
   input logic                rsp_curvature_valid
);

   `LCOM_ASSERT_HOLD(a_rsp_index_hold, rsp_valid, rsp_ready, rsp_point_index, "rsp beat changed while stalled")

   `LCOM_ASSERT(a_curv_zero_when_invalid, rsp_valid && !rsp_curvature_valid |-> rsp_curvature == '0, "curvature set on an edge point")

   `LCOM_ASSERT(a_flush_blocks_input, req_valid && req_ready && req_last |=> !req_ready, "input taken during flush")

   `LCOM_ASSERT(a_flush_gives_result, req_valid && req_ready && req_last |-> ##2 rsp_valid, "flush produced no result")

endmodule

bind lidar_curvature_occlusion_marker lcom_checker u_lcom_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_in.valid),
   .req_ready           (req_in.ready),
   .req_last            (req_in.last_point),
   .rsp_valid           (rsp_out.valid),
   .rsp_ready           (rsp_out.ready),
   .rsp_point_index     (rsp_out.point_index),
   .rsp_curvature       (rsp_out.curvature),
   .rsp_curvature_valid (rsp_out.curvature_valid)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import lcom_pkg::*;

   localparam int RANGE_HIST   = 17;
   localparam int OUT_DELAY    = 11;
   localparam int RANGE_TOP    = (1 << RANGE_W) - 1;
   localparam int COLUMN_TOP   = COLUMNS - 1;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int LONG_HOLD    = 400;
   localparam int LONG_SCAN    = 40;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_type;
   typedef enum int {SCAN_PROFILE, SCAN_NOISE} scan_style_type;

   typedef struct {
      logic [RANGE_W-1:0]  range_mm;
      logic [COLUMN_W-1:0] column;
      logic                is_last;
   } point_type;

   typedef struct {
      logic [INDEX_W-1:0]  point_index;
      logic [RANGE_W-1:0]  range_mm;
      logic [COLUMN_W-1:0] column;
      logic [CURV_W-1:0]   curvature;
      logic                curv_ok;
      logic                excluded;
      logic                scan_end;
   } mark_type;

   logic clock;
   logic reset;

   lcom_req_if req_bus ();
   lcom_rsp_if rsp_bus ();
   lcom_csr_if csr_bus ();

   lidar_curvature_occlusion_marker uut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_bus),
      .rsp_out (rsp_bus),
      .csr_in  (csr_bus)
   );

   point_type point_queue[$];
   mark_type  pending_marks[$];

   bit [RANGE_W-1:0]  range_hist [RANGE_HIST];
   bit [COLUMN_W-1:0] col_hist [WIN_DEPTH];
   bit                excl_hist [WIN_DEPTH];
   bit [INDEX_W-1:0]  scan_pos;
   int                scan_fill;
   bit [GAP_W-1:0]    cfg_gap;
   bit [LIMIT_W-1:0]  cfg_limit;
   bit [RATIO_W-1:0]  cfg_ratio;

   bit            req_beat_taken;
   bit            rsp_beat_taken;
   bit            req_on_bus;
   int            req_wait;
   int            rsp_wait;
   int            rsp_hold_left;
   int            hold_request;
   idle_mode_type send_mode;
   idle_mode_type recv_mode;
   int            mismatch_count;
   int            cycle_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int draw_wait(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: return 0;
         IDLE_FULL: return int'($urandom_range(0, 17));
         default:   return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
      endcase
   endfunction

   function automatic longint unsigned span(input longint unsigned a, input longint unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic void clear_scan();
      for (int i = 0; i < RANGE_HIST; i++) range_hist[i] = '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         col_hist[i] = '0;
         excl_hist[i] = 1'b0;
      end
      scan_pos = '0;
      scan_fill = 0;
   endfunction

   function automatic logic [CURV_W-1:0] window_curvature(input int d);
      longint acc;
      longint unsigned sq;
      acc = 0;
      for (int j = d - NEIGH; j <= d + NEIGH; j++)
         if (j != d) acc += longint'(range_hist[j]);
      acc -= 10 * longint'(range_hist[d]);
      if (acc < 0) acc = -acc;
      sq = acc * acc;
      if (sq > CURV_MAX) return CURV_MAX;
      return sq[CURV_W-1:0];
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_OCCLUSION_GAP:  cfg_gap = val[GAP_W-1:0];
         CSR_COLUMN_GAP:     cfg_limit = val[LIMIT_W-1:0];
         CSR_PARALLEL_RATIO: cfg_ratio = val[RATIO_W-1:0];
         default: ;
      endcase
   endfunction

   // shift one point in, run the tests six back, queue the results it releases
   function automatic void mark_point(input logic [RANGE_W-1:0] r, input logic [COLUMN_W-1:0] c,
                                      input logic is_last);
      bit [INDEX_W-1:0] cur;
      longint unsigned ri, rn, rp, lim;
      int oldest, stop;
      bit ok;
      mark_type m;
      cur = scan_pos;
      if (c > COLUMN_MAX) c = COLUMN_MAX;
      for (int i = RANGE_HIST - 1; i > 0; i--) range_hist[i] = range_hist[i-1];
      for (int i = WIN_DEPTH - 1; i > 0; i--) begin
         col_hist[i] = col_hist[i-1];
         excl_hist[i] = excl_hist[i-1];
      end
      range_hist[0] = r;
      col_hist[0] = c;
      excl_hist[0] = 1'b0;
      if (scan_fill < RANGE_HIST) scan_fill++;
      scan_pos = cur + 1'b1;

      if (scan_fill >= WIN_DEPTH) begin
         ri = range_hist[6];
         rn = range_hist[5];
         rp = range_hist[7];
         if (span(col_hist[5], col_hist[6]) < cfg_limit) begin
            if (ri > rn && ri - rn > cfg_gap) begin
               for (int i = 6; i <= 11; i++) excl_hist[i] = 1'b1;
            end else if (rn > ri && rn - ri > cfg_gap) begin
               for (int i = 0; i <= 5; i++) excl_hist[i] = 1'b1;
            end
         end
         lim = longint'(cfg_ratio) * ri;
         if (span(rp, ri) * 1000 > lim && span(rn, ri) * 1000 > lim) excl_hist[6] = 1'b1;
      end

      oldest = ((scan_fill < WIN_DEPTH) ? scan_fill : WIN_DEPTH) - 1;
      stop = is_last ? 0 : OUT_DELAY;
      if (is_last || scan_fill >= WIN_DEPTH) begin
         for (int d = oldest; d >= stop; d--) begin
            ok = (d >= NEIGH) && (scan_fill >= d + NEIGH + 1);
            m.point_index = cur - INDEX_W'(d);
            m.range_mm = range_hist[d];
            m.column = col_hist[d];
            m.curvature = ok ? window_curvature(d) : '0;
            m.curv_ok = ok;
            m.excluded = excl_hist[d];
            m.scan_end = is_last && (d == 0);
            pending_marks = {pending_marks, m};
         end
      end
      if (is_last) clear_scan();
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   task automatic check_mark();
      mark_type want;
      if (pending_marks.size() == 0) begin
         report_mismatch("result beat with no result pending");
         return;
      end
      want = pending_marks.pop_front();
      check_field("point_index", rsp_bus.point_index, want.point_index);
      check_field("range_out", rsp_bus.range_out, want.range_mm);
      check_field("column_out", rsp_bus.column_out, want.column);
      check_field("curvature", rsp_bus.curvature, want.curvature);
      check_field("curvature_valid", rsp_bus.curvature_valid, want.curv_ok);
      check_field("excluded", rsp_bus.excluded, want.excluded);
      check_field("scan_end", rsp_bus.scan_end, want.scan_end);
   endtask

   // sample all three channels
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) apply_csr(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready) begin
            mark_point(req_bus.range_mm, req_bus.column, req_bus.last_point);
            req_beat_taken = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_mark();
            rsp_beat_taken = 1'b1;
         end
      end
   end

   // point driver
   always @(negedge clock) begin : feed
      point_type p;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_beat_taken) begin
            req_beat_taken = 1'b0;
            req_on_bus = 1'b0;
         end
         if (!req_on_bus) begin
            if (req_wait > 0) begin
               req_wait--;
               req_bus.valid <= 1'b0;
            end else if (point_queue.size() != 0) begin
               p = point_queue.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.range_mm <= p.range_mm;
               req_bus.column <= p.column;
               req_bus.last_point <= p.is_last;
               req_on_bus = 1'b1;
               req_wait = draw_wait(send_mode);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result ready
   always @(negedge clock) begin
      if (rsp_beat_taken) begin
         rsp_beat_taken = 1'b0;
         rsp_wait = draw_wait(recv_mode);
      end
      if (rsp_hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_request != 0) begin
         rsp_hold_left = hold_request;
         hold_request = 0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left--;
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic push_point(input int r, input int c, input bit is_last);
      point_type p;
      p.range_mm = RANGE_W'(r);
      p.column = COLUMN_W'(c);
      p.is_last = is_last;
      point_queue = {point_queue, p};
   endtask

   task automatic queue_scan(input int len, input scan_style_type style);
      int level, col, k, delta, sample;
      level = $urandom_range(0, RANGE_TOP);
      col = $urandom_range(0, COLUMN_TOP);
      for (int i = 0; i < len; i++) begin
         if (i != 0) begin
            k = $urandom_range(0, 19);
            case (k)
               0: col += int'($urandom_range(2, 30));
               1: col = $urandom_range(0, COLUMN_TOP);
               2: ;
               3: col -= 1;
               default: col += 1;
            endcase
            col = col & COLUMN_TOP;
         end
         if (style == SCAN_NOISE) begin
            sample = $urandom_range(0, RANGE_TOP);
         end else begin
            k = $urandom_range(0, 15);
            sample = -1;
            case (k)
               0, 1: level = $urandom_range(0, RANGE_TOP);
               2: sample = $urandom_range(0, RANGE_TOP);
               3: begin
                  delta = int'($urandom_range(200, 8000));
                  if ($urandom_range(0, 1) == 0) delta = -delta;
                  level += delta;
               end
               4: level = ($urandom_range(0, 1) == 0) ? 0 : RANGE_TOP;
               default: level += int'($urandom_range(0, 80)) - 40;
            endcase
            if (level < 0) level = 0;
            if (level > RANGE_TOP) level = RANGE_TOP;
            if (sample < 0) sample = level;
         end
         push_point(sample, col, i == len - 1);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (point_queue.size() != 0 || req_bus.valid || pending_marks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int target, input idle_mode_type s_mode,
                            input idle_mode_type r_mode);
      int count, len;
      scan_style_type style;
      send_mode = s_mode;
      recv_mode = r_mode;
      count = 0;
      while (count < target) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(12, 40);
         style = ($urandom_range(0, 5) == 0) ? SCAN_NOISE : SCAN_PROFILE;
         queue_scan(len, style);
         count += len;
      end
      wait_drained();
   endtask

   function automatic idle_mode_type any_mode();
      return idle_mode_type'($urandom_range(0, 2));
   endfunction

   task automatic random_config();
      csr_write(CSR_OCCLUSION_GAP, CSR_DATA_W'($urandom_range(0, 3000)));
      csr_write(CSR_COLUMN_GAP, CSR_DATA_W'($urandom_range(0, 64)));
      csr_write(CSR_PARALLEL_RATIO, CSR_DATA_W'($urandom_range(0, 1000)));
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.range_mm = '0;
      req_bus.column = '0;
      req_bus.last_point = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_OCCLUSION_GAP;
      csr_bus.data = '0;
      req_beat_taken = 1'b0;
      rsp_beat_taken = 1'b0;
      req_on_bus = 1'b0;
      req_wait = 0;
      rsp_wait = 0;
      rsp_hold_left = 0;
      hold_request = 0;
      mismatch_count = 0;
      cycle_count = 0;
      send_mode = IDLE_FULL;
      recv_mode = IDLE_FULL;
      cfg_gap = GAP_RESET;
      cfg_limit = LIMIT_RESET;
      cfg_ratio = RATIO_RESET;
      clear_scan();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single point scan, three point scan
      push_point(RANGE_TOP, COLUMN_TOP, 1'b1);
      push_point(0, 0, 1'b0);
      push_point(RANGE_TOP, 'h555, 1'b0);
      push_point('h15555, 'h2aa, 1'b1);
      // peak curvature with spike, far-side and near-side occlusion
      for (int i = 0; i < 17; i++)
         push_point((i == 5) ? RANGE_TOP : ((i >= 11) ? 40000 : 0), COLUMN_TOP - 16 + i,
                    i == 16);
      wait_drained();

      csr_write(CSR_OCCLUSION_GAP, CSR_DATA_W'(300));
      csr_write(CSR_COLUMN_GAP, CSR_DATA_W'(10));
      csr_write(CSR_PARALLEL_RATIO, CSR_DATA_W'(20));
      csr_write(CSR_SPARE, 16'hffff);
      run_phase(60, any_mode(), any_mode());

      csr_write(CSR_OCCLUSION_GAP, 16'd0);
      csr_write(CSR_COLUMN_GAP, CSR_DATA_W'(COLUMN_TOP));
      csr_write(CSR_PARALLEL_RATIO, 16'd0);
      run_phase(50, IDLE_NONE, IDLE_NONE);

      csr_write(CSR_OCCLUSION_GAP, 16'hffff);
      csr_write(CSR_COLUMN_GAP, 16'd0);
      csr_write(CSR_PARALLEL_RATIO, 16'd1000);
      run_phase(50, any_mode(), any_mode());

      // receiver stalls while points keep coming
      random_config();
      @(negedge clock);
      hold_request = LONG_HOLD;
      run_phase(80, IDLE_NONE, IDLE_FULL);

      csr_write(CSR_OCCLUSION_GAP, 16'd1);
      csr_write(CSR_COLUMN_GAP, 16'hf805);
      csr_write(CSR_PARALLEL_RATIO, 16'hffe8);
      run_phase(60, IDLE_FULL, IDLE_SPARSE);

      random_config();
      run_phase(60, any_mode(), any_mode());

      // one longer scan with no idling
      csr_write(CSR_OCCLUSION_GAP, 16'd400);
      csr_write(CSR_COLUMN_GAP, 16'd3);
      csr_write(CSR_PARALLEL_RATIO, 16'd30);
      send_mode = IDLE_NONE;
      recv_mode = IDLE_NONE;
      queue_scan(LONG_SCAN, SCAN_PROFILE);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
